// ===== rtl/mdd_pkg.sv =====
// Shared types, constants and decode functions for the Manchester deframer.
package mdd_pkg;

  // Default raw byte limit of one packet.
  localparam int MAX_RAW_BYTES_DEF = 512;

  // Queue between the front and back halves.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Field widths.
  localparam int LEN_W = 9;
  localparam int SYM_W = 12;

  // Saturation value of the bad symbol counter.
  localparam logic [SYM_W-1:0] BAD_MAX = '1;

  // Smallest valid L-field (L + 1 >= 12); every 8-bit L meets the upper bound.
  localparam logic [7:0] LFIELD_MIN = 8'd11;
  // L-fields below this value fit in the first two blocks.
  localparam logic [7:0] LFIELD_FIRST_BLOCK = 8'd26;
  // Fewer raw bytes than this make a packet too short.
  localparam int MIN_RAW_BYTES = 6;

  // Valid Manchester symbol pairs, named by their normal-polarity meaning.
  localparam logic [1:0] PAIR_ZERO = 2'b01;
  localparam logic [1:0] PAIR_ONE  = 2'b10;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_LFIELD = 2'd2,
    ST_TRUNC  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    kind_t              item_kind;
    logic [7:0]         byte_normal;
    logic [7:0]         byte_inverted;
    logic [7:0]         byte_position;
    logic               keep_normal;
    logic               keep_inverted;
    status_t            status;
    logic               chosen_polarity;
    logic [LEN_W-1:0]   frame_length;
    logic [SYM_W-1:0]   symbol_count;
    logic [SYM_W-1:0]   bad_symbol_count;
    logic               last;
  } out_item_t;

  // Up to two result items written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  e0;
    out_item_t  e1;
  } push_t;

  // Queue fill status seen by the front half.
  typedef struct packed {
    logic              room2;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Oldest queue entry offered to the back half.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } q_head_t;

  // Decoded nibbles of one raw byte in both polarities.
  typedef struct packed {
    logic [3:0] nib_n;
    logic [3:0] nib_i;
    logic [2:0] nbad;
  } nib_t;

  function automatic nib_t decode_nibble(input logic [7:0] raw);
    nib_t       r;
    logic [1:0] pair;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      pair    = raw[7-2*k -: 2];
      r.nib_n = {r.nib_n[2:0], pair == PAIR_ONE};
      r.nib_i = {r.nib_i[2:0], pair == PAIR_ZERO};
      if (pair != PAIR_ZERO && pair != PAIR_ONE) begin
        r.nbad = r.nbad + 3'd1;
      end
    end
    return r;
  endfunction

  // Format-A frame length including the CRC bytes: L + 1 + 2 * blocks.
  function automatic logic [LEN_W-1:0] frame_len(input logic [7:0] l);
    logic [7:0] over;
    over = l - LFIELD_FIRST_BLOCK;
    if (l < LFIELD_FIRST_BLOCK) begin
      return LEN_W'(l) + 9'd5;
    end
    return LEN_W'(l) + 9'd7 + {4'd0, over[7:4], 1'b0};
  endfunction

  function automatic logic lfield_valid(input logic [7:0] l);
    return l >= LFIELD_MIN;
  endfunction

endpackage

// ===== rtl/mdd_in_if.sv =====
// Raw byte channel: valid/ready handshake with the raw byte payload.
interface mdd_in_if;
  logic              valid;
  logic              ready;
  mdd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mdd_out_if.sv =====
// Result channel: valid/ready handshake with the decoded result payload.
interface mdd_out_if;
  logic               valid;
  logic               ready;
  mdd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mdd_front.sv =====
// Front half: accepts raw bytes, decodes both polarities and builds result items.
module mdd_front #(
  parameter int MAX_RAW_BYTES = mdd_pkg::MAX_RAW_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mdd_in_if.sink           in_ch,
  input  mdd_pkg::q_stat_t q_stat,
  output mdd_pkg::push_t   push
);

  localparam int RAW_CNT_W = $clog2(MAX_RAW_BYTES + 1);
  localparam int DEC_W     = RAW_CNT_W - 1;
  localparam int CMP_W     = (DEC_W > mdd_pkg::LEN_W) ? DEC_W : mdd_pkg::LEN_W;

  logic [3:0]                 half_n_r, half_n_nxt;
  logic [3:0]                 half_i_r, half_i_nxt;
  logic                       odd_phase_r, odd_phase_nxt;
  logic [RAW_CNT_W-1:0]       raw_count_r, raw_count_nxt;
  logic [mdd_pkg::SYM_W-1:0]  bad_count_r, bad_count_nxt;
  logic [mdd_pkg::LEN_W-1:0]  len_n_r, len_n_nxt;
  logic [mdd_pkg::LEN_W-1:0]  len_i_r, len_i_nxt;
  logic [1:0]                 lf_ok_r, lf_ok_nxt;

  logic                       accept;
  logic                       take;
  logic                       pair_done;
  logic                       lfield_byte;
  mdd_pkg::nib_t              nib;
  logic [7:0]                 dn, di;
  logic [DEC_W-1:0]           pos_full;
  logic [mdd_pkg::LEN_W-1:0]  len_n_eff, len_i_eff;
  logic [1:0]                 lf_ok_eff;
  logic [RAW_CNT_W-1:0]       raw_inc;
  logic [DEC_W-1:0]           dec_total;
  logic [mdd_pkg::SYM_W:0]    bad_sum;
  logic [mdd_pkg::SYM_W-1:0]  bad_inc;
  mdd_pkg::status_t           st_n, st_i;
  logic                       pol;
  mdd_pkg::out_item_t         pair_item, stat_item;

  // A new raw byte is taken only when the queue can hold two results.
  assign in_ch.ready = q_stat.room2;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = accept && (raw_count_r < RAW_CNT_W'(MAX_RAW_BYTES));

  // Symbol decoding of the incoming byte.
  assign nib         = mdd_pkg::decode_nibble(in_ch.data.raw_byte);
  assign pair_done   = take && odd_phase_r;
  assign pos_full    = raw_count_r[RAW_CNT_W-1:1];
  assign lfield_byte = pair_done && (pos_full == '0);
  assign dn          = {half_n_r, nib.nib_n};
  assign di          = {half_i_r, nib.nib_i};

  // The first decoded byte is the L-field; it sets the lengths at once.
  assign len_n_eff = lfield_byte ? mdd_pkg::frame_len(dn) : len_n_r;
  assign len_i_eff = lfield_byte ? mdd_pkg::frame_len(di) : len_i_r;
  assign lf_ok_eff = lfield_byte ? {mdd_pkg::lfield_valid(di), mdd_pkg::lfield_valid(dn)}
                                 : lf_ok_r;

  // Counters including the current byte.
  assign raw_inc   = take ? raw_count_r + RAW_CNT_W'(1) : raw_count_r;
  assign dec_total = raw_inc[RAW_CNT_W-1:1];
  assign bad_sum   = {1'b0, bad_count_r} + (take ? (mdd_pkg::SYM_W + 1)'(nib.nbad) : '0);
  assign bad_inc   = (bad_sum > {1'b0, mdd_pkg::BAD_MAX}) ? mdd_pkg::BAD_MAX
                                                          : bad_sum[mdd_pkg::SYM_W-1:0];

  // Decoded byte pair item.
  always_comb begin
    pair_item               = '0;
    pair_item.item_kind     = mdd_pkg::KIND_DATA;
    pair_item.byte_normal   = dn;
    pair_item.byte_inverted = di;
    pair_item.byte_position = 8'(pos_full);
    pair_item.keep_normal   = CMP_W'(pos_full) < CMP_W'(len_n_eff);
    pair_item.keep_inverted = CMP_W'(pos_full) < CMP_W'(len_i_eff);
  end

  // Per-polarity verdicts and the polarity that gets reported.
  always_comb begin
    if (!lf_ok_eff[0]) begin
      st_n = mdd_pkg::ST_LFIELD;
    end else if (CMP_W'(dec_total) < CMP_W'(len_n_eff)) begin
      st_n = mdd_pkg::ST_TRUNC;
    end else begin
      st_n = mdd_pkg::ST_OK;
    end
    if (!lf_ok_eff[1]) begin
      st_i = mdd_pkg::ST_LFIELD;
    end else if (CMP_W'(dec_total) < CMP_W'(len_i_eff)) begin
      st_i = mdd_pkg::ST_TRUNC;
    end else begin
      st_i = mdd_pkg::ST_OK;
    end
    if (st_n == mdd_pkg::ST_OK) begin
      pol = 1'b0;
    end else if (st_i == mdd_pkg::ST_OK) begin
      pol = 1'b1;
    end else if (st_n == mdd_pkg::ST_LFIELD && st_i == mdd_pkg::ST_TRUNC) begin
      pol = 1'b1;
    end else begin
      pol = 1'b0;
    end
  end

  // Final status item.
  always_comb begin
    stat_item           = '0;
    stat_item.item_kind = mdd_pkg::KIND_STATUS;
    stat_item.last      = 1'b1;
    if (raw_inc < RAW_CNT_W'(mdd_pkg::MIN_RAW_BYTES)) begin
      stat_item.status = mdd_pkg::ST_SHORT;
    end else begin
      stat_item.status           = pol ? st_i : st_n;
      stat_item.chosen_polarity  = pol;
      stat_item.frame_length     = pol ? len_i_eff : len_n_eff;
      stat_item.symbol_count     = mdd_pkg::SYM_W'({raw_inc, 2'b00});
      stat_item.bad_symbol_count = bad_inc;
    end
  end

  // Results handed to the queue, oldest first.
  always_comb begin
    push     = '0;
    push.cnt = {1'b0, pair_done} + {1'b0, accept && in_ch.data.end_of_packet};
    push.e0  = pair_done ? pair_item : stat_item;
    push.e1  = stat_item;
  end

  // Packet state update; the end of a packet clears everything.
  always_comb begin
    half_n_nxt    = half_n_r;
    half_i_nxt    = half_i_r;
    odd_phase_nxt = odd_phase_r;
    raw_count_nxt = raw_count_r;
    bad_count_nxt = bad_count_r;
    len_n_nxt     = len_n_r;
    len_i_nxt     = len_i_r;
    lf_ok_nxt     = lf_ok_r;
    if (accept && in_ch.data.end_of_packet) begin
      half_n_nxt    = '0;
      half_i_nxt    = '0;
      odd_phase_nxt = 1'b0;
      raw_count_nxt = '0;
      bad_count_nxt = '0;
      len_n_nxt     = '0;
      len_i_nxt     = '0;
      lf_ok_nxt     = '0;
    end else if (take) begin
      if (!odd_phase_r) begin
        half_n_nxt = nib.nib_n;
        half_i_nxt = nib.nib_i;
      end
      odd_phase_nxt = !odd_phase_r;
      raw_count_nxt = raw_inc;
      bad_count_nxt = bad_inc;
      len_n_nxt     = len_n_eff;
      len_i_nxt     = len_i_eff;
      lf_ok_nxt     = lf_ok_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_n_r    <= '0;
      half_i_r    <= '0;
      odd_phase_r <= 1'b0;
      raw_count_r <= '0;
      bad_count_r <= '0;
      len_n_r     <= '0;
      len_i_r     <= '0;
      lf_ok_r     <= '0;
    end else begin
      half_n_r    <= half_n_nxt;
      half_i_r    <= half_i_nxt;
      odd_phase_r <= odd_phase_nxt;
      raw_count_r <= raw_count_nxt;
      bad_count_r <= bad_count_nxt;
      len_n_r     <= len_n_nxt;
      len_i_r     <= len_i_nxt;
      lf_ok_r     <= lf_ok_nxt;
    end
  end

endmodule

// ===== rtl/mdd_queue.sv =====
// Short result queue between the front and back halves, two writes and one read a cycle.
module mdd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mdd_pkg::push_t   push,
  input  logic             pop,
  output mdd_pkg::q_stat_t stat,
  output mdd_pkg::q_head_t head
);

  mdd_pkg::out_item_t              mem_r [mdd_pkg::QUEUE_DEPTH];
  logic [mdd_pkg::QPTR_W-1:0]      wp_r, wp_nxt;
  logic [mdd_pkg::QPTR_W-1:0]      rp_r, rp_nxt;
  logic [mdd_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic [mdd_pkg::QPTR_W-1:0]      wp_next1;

  assign wp_next1 = wp_r + mdd_pkg::QPTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    wp_nxt    = wp_r + mdd_pkg::QPTR_W'(push.cnt);
    rp_nxt    = pop ? rp_r + mdd_pkg::QPTR_W'(1) : rp_r;
    count_nxt = count_r + mdd_pkg::QCNT_W'(push.cnt) - mdd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.e0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_next1] <= push.e1;
    end
  end

  assign stat.room2 = count_r <= mdd_pkg::QCNT_W'(mdd_pkg::QUEUE_DEPTH - 2);
  assign stat.count = count_r;
  assign head.valid = count_r != '0;
  assign head.item  = mem_r[rp_r];

endmodule

// ===== rtl/mdd_back.sv =====
// Back half: output register that presents results on the result channel.
module mdd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mdd_pkg::q_head_t head,
  output logic             pop,
  mdd_out_if.source        out_ch
);

  logic               out_valid_r, out_valid_nxt;
  mdd_pkg::out_item_t out_data_r;

  // Load a new result whenever the register is empty or being drained.
  assign pop           = head.valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head.item;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== rtl/manchester_dual_polarity_deframer_core.sv =====
// Top level of the dual-polarity Manchester deframer.
//
// Raw radio bytes arrive MSB first, four Manchester symbol pairs each, and are
// decoded in both polarities at once. A raw byte is taken in every cycle while
// the result queue holds at most two entries; every second raw byte yields one
// decoded byte pair, and the byte that ends a packet also yields a status item,
// so the end of a packet can put two results into the queue in one cycle. The
// result channel drains one item per cycle while its ready is high, through a
// four-entry queue and an output register; a result is written into the queue
// when its raw byte is taken and is presented once it has moved on into the
// output register. The input stalls only when the queue is nearly full. Raw
// bytes beyond MAX_RAW_BYTES in a packet are dropped, though an end marker on
// one still closes the packet. There is no clearing pass after reset.
module manchester_dual_polarity_deframer_core #(
  parameter int MAX_RAW_BYTES = mdd_pkg::MAX_RAW_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mdd_in_if.sink    in_ch,
  mdd_out_if.source out_ch
);

  mdd_pkg::push_t   push;
  mdd_pkg::q_stat_t q_stat;
  mdd_pkg::q_head_t q_head;
  logic             pop;

  // Decode and packet bookkeeping.
  mdd_front #(
    .MAX_RAW_BYTES(MAX_RAW_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push)
  );

  // Decoupling queue.
  mdd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (q_stat),
    .head  (q_head)
  );

  // Output register.
  mdd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // The end of a packet always queues a status item as its final result.
  a_eop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.end_of_packet) |->
      (((push.cnt == 2'd1) && push.e0.last) || ((push.cnt == 2'd2) && push.e1.last)))
    else $error("end of packet did not queue a final status item");

  // The queue never holds more entries than it has.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= mdd_pkg::QCNT_W'(mdd_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // A transfer marked last is a status item.
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.data.last) |->
      (out_ch.data.item_kind == mdd_pkg::KIND_STATUS))
    else $error("last flag on a data transfer");

endmodule
